/* sv/vob_pkg.sv */
// Shared types and constants for the voxel occupancy binning block.
package vob_pkg;

    // Item kinds
    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Configuration port widths
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    typedef logic [CFG_IDX_W-1:0]  t_cfg_index;
    typedef logic [CFG_DATA_W-1:0] t_cfg_data;

    // Configuration register indexes
    localparam t_cfg_index CFG_WIDTH_X  = 4'd0;
    localparam t_cfg_index CFG_WIDTH_Y  = 4'd1;
    localparam t_cfg_index CFG_WIDTH_Z  = 4'd2;
    localparam t_cfg_index CFG_SHIFT_X  = 4'd3;
    localparam t_cfg_index CFG_SHIFT_Y  = 4'd4;
    localparam t_cfg_index CFG_SHIFT_Z  = 4'd5;
    localparam t_cfg_index CFG_INV_STEP = 4'd6;
    localparam t_cfg_index CFG_BORDER   = 4'd7;

    // Input word
    typedef struct packed {
        logic              kind;
        logic signed [23:0] x_coord;
        logic signed [23:0] y_coord;
        logic signed [23:0] z_coord;
        logic [5:0]        voxel_x;
        logic [5:0]        voxel_y;
        logic [5:0]        voxel_z;
    } t_in_word;

    // Result word
    typedef struct packed {
        logic        placed;
        logic [15:0] voxel_count;
        logic [31:0] points_seen;
    } t_out_word;

endpackage

/* sv/vob_axis.sv */
// One axis lane: scales a coordinate to a voxel index and checks grid and border.
module vob_axis #(
    parameter int GRID_DIM = 64
) (
    input  logic                        i_clk,
    input  logic                        i_mul_en,
    input  logic                        i_idx_en,
    input  logic signed [23:0]          i_coord,
    input  logic signed [12:0]          i_shift,
    input  logic [6:0]                  i_width,
    input  logic [23:0]                 i_inv_step,
    input  logic [4:0]                  i_border,
    output logic [$clog2(GRID_DIM)-1:0] o_idx,
    output logic                        o_ok
);
    localparam int IW = $clog2(GRID_DIM);
    localparam logic [49:0] HALF_LSB = 50'd1 << 23;
    localparam logic signed [27:0] GRID_S = 28'(GRID_DIM);

    logic signed [25:0] w_pos;
    logic [24:0]        w_mag;
    logic [48:0]        r_prod;
    logic               r_neg;
    logic [49:0]        w_rnd;
    logic [25:0]        w_round;
    logic signed [27:0] w_rsig;
    logic signed [27:0] w_width;
    logic signed [27:0] w_eff;
    logic signed [27:0] w_border;
    logic signed [27:0] w_g;
    logic               w_ok;
    logic [IW-1:0]      r_idx;
    logic               r_ok;

    // Stage 1: add offset (Q.8), take magnitude, scale by reciprocal step
    assign w_pos = 26'(i_coord) + (26'(i_shift) <<< 8);
    assign w_mag = w_pos[25] ? 25'(-w_pos) : 25'(w_pos);

    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= 49'(w_mag) * 49'(i_inv_step);
            r_neg  <= w_pos[25];
        end
    end

    // Stage 2: round half away from zero, restore sign, center, range check
    assign w_rnd    = {1'b0, r_prod} + HALF_LSB;
    assign w_round  = w_rnd[49:24];
    assign w_rsig   = r_neg ? -signed'({2'b00, w_round}) : signed'({2'b00, w_round});
    assign w_width  = signed'({21'd0, i_width});
    assign w_eff    = (w_width > GRID_S) ? GRID_S : w_width;
    assign w_border = signed'({23'd0, i_border});
    assign w_g      = w_rsig + (w_eff >>> 1);
    assign w_ok     = (w_g >= w_border + 28'sd1) && (w_g < w_eff) && (w_g <= w_eff - w_border);

    always_ff @(posedge i_clk) begin
        if (i_idx_en) begin
            r_idx <= IW'(w_g);
            r_ok  <= w_ok;
        end
    end

    assign o_idx = r_idx;
    assign o_ok  = r_ok;

endmodule

/* sv/vob_store.sv */
// Occupancy counter memory with registered read and a clearing sweep after reset.
module vob_store #(
    parameter int DEPTH = 262144,
    parameter int DW    = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [DW-1:0]            o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [DW-1:0]            i_wr_data,
    output logic                     o_busy
);
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;
    logic [AW-1:0] r_clr_addr;
    logic          r_clearing;

    // Clear sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == LAST) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Memory port: write (sweep has priority) and registered read
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clearing;

endmodule

/* sv/voxel_occupancy_binning.sv */
// Top level: voxel occupancy binning with control sequencer and configuration registers.
//
//   channel  direction  signals                                      word
//   in       sink       i_in_valid / o_in_ready / i_in_word          t_in_word
//   out      source     o_out_valid / i_out_ready / o_out_word       t_out_word
//   cfg      sink       i_cfg_valid / o_cfg_ready / i_cfg_index,data register write
//
// An item occupies the block from accept through multiply, round and range check,
// address, memory read, update and write-back through the memory's write port. Its
// result word is registered at write-back. Only one item is in flight, so a
// read-modify-write never overlaps.
// After reset a sweep clears the counter memory, all GRID_DIM^3 entries (262144 at the
// default); no item is accepted meanwhile, configuration writes are.
// A stalled output holds the sequencer in write-back; the next input is still
// accepted while a finished result waits.
module voxel_occupancy_binning #(
    parameter int GRID_DIM   = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  vob_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output vob_pkg::t_out_word  o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  vob_pkg::t_cfg_index i_cfg_index,
    input  vob_pkg::t_cfg_data  i_cfg_data
);
    import vob_pkg::*;

    localparam int IW    = $clog2(GRID_DIM);
    localparam int CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(CELLS);
    localparam logic [AW-1:0] ROW   = AW'(GRID_DIM);
    localparam logic [AW-1:0] PLANE = AW'(GRID_DIM * GRID_DIM);
    localparam logic [7:0]    GRID8 = 8'(GRID_DIM - 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_IDX  = 6'b000100,
        ST_ADDR = 6'b001000,
        ST_RD   = 6'b010000,
        ST_WB   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers
    logic [6:0]         r_width_x, r_width_y, r_width_z;
    logic signed [12:0] r_shift_x, r_shift_y, r_shift_z;
    logic [23:0]        r_inv_step;
    logic [4:0]         r_border;

    t_in_word       r_in;
    logic [AW-1:0]  r_addr;
    logic           r_hit;
    logic [31:0]    r_total;
    logic           r_out_valid;
    t_out_word      r_out_word;

    logic [IW-1:0]     w_ix, w_iy, w_iz;
    logic              w_okx, w_oky, w_okz;
    logic              w_busy;
    logic [COUNT_BITS-1:0] w_rd_data;
    logic [COUNT_BITS-1:0] w_inc;
    logic              w_rd_en, w_wr_en;
    logic              w_out_free;
    logic              w_accept;
    logic              w_is_add;
    logic              w_rd_in_range;
    logic [AW-1:0]     w_add_addr, w_rd_addr_calc;
    logic [31:0]       w_total_inc;
    t_out_word         w_result;

    assign o_cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_x  <= 7'd64;
            r_width_y  <= 7'd64;
            r_width_z  <= 7'd64;
            r_shift_x  <= '0;
            r_shift_y  <= '0;
            r_shift_z  <= '0;
            r_inv_step <= 24'd65536;
            r_border   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH_X:  r_width_x  <= i_cfg_data[6:0];
                CFG_WIDTH_Y:  r_width_y  <= i_cfg_data[6:0];
                CFG_WIDTH_Z:  r_width_z  <= i_cfg_data[6:0];
                CFG_SHIFT_X:  r_shift_x  <= signed'(i_cfg_data[12:0]);
                CFG_SHIFT_Y:  r_shift_y  <= signed'(i_cfg_data[12:0]);
                CFG_SHIFT_Z:  r_shift_z  <= signed'(i_cfg_data[12:0]);
                CFG_INV_STEP: r_inv_step <= i_cfg_data;
                CFG_BORDER:   r_border   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Input capture
    assign o_in_ready = (r_state == ST_IDLE) && !w_busy;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_word;
        end
    end

    // Axis lanes
    vob_axis #(.GRID_DIM(GRID_DIM)) u_axis_x (
        .i_clk(i_clk), .i_mul_en(r_state == ST_MUL), .i_idx_en(r_state == ST_IDX),
        .i_coord(r_in.x_coord), .i_shift(r_shift_x), .i_width(r_width_x),
        .i_inv_step(r_inv_step), .i_border(r_border), .o_idx(w_ix), .o_ok(w_okx)
    );
    vob_axis #(.GRID_DIM(GRID_DIM)) u_axis_y (
        .i_clk(i_clk), .i_mul_en(r_state == ST_MUL), .i_idx_en(r_state == ST_IDX),
        .i_coord(r_in.y_coord), .i_shift(r_shift_y), .i_width(r_width_y),
        .i_inv_step(r_inv_step), .i_border(r_border), .o_idx(w_iy), .o_ok(w_oky)
    );
    vob_axis #(.GRID_DIM(GRID_DIM)) u_axis_z (
        .i_clk(i_clk), .i_mul_en(r_state == ST_MUL), .i_idx_en(r_state == ST_IDX),
        .i_coord(r_in.z_coord), .i_shift(r_shift_z), .i_width(r_width_z),
        .i_inv_step(r_inv_step), .i_border(r_border), .o_idx(w_iz), .o_ok(w_okz)
    );

    // Address for add and read items
    assign w_is_add = (r_in.kind == KIND_ADD);
    assign w_add_addr = AW'(w_ix) + AW'(w_iy) * ROW + AW'(w_iz) * PLANE;
    assign w_rd_in_range = ({2'b00, r_in.voxel_x} <= GRID8) &&
                           ({2'b00, r_in.voxel_y} <= GRID8) &&
                           ({2'b00, r_in.voxel_z} <= GRID8);
    assign w_rd_addr_calc = AW'(IW'(r_in.voxel_x)) + AW'(IW'(r_in.voxel_y)) * ROW +
                            AW'(IW'(r_in.voxel_z)) * PLANE;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ADDR) begin
            r_addr <= w_is_add ? w_add_addr : w_rd_addr_calc;
            r_hit  <= w_is_add ? (w_okx && w_oky && w_okz) : w_rd_in_range;
        end
    end

    // Counter memory
    assign w_rd_en     = (r_state == ST_RD) && r_hit;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_inc       = (w_rd_data == '1) ? w_rd_data : w_rd_data + 1'b1;
    assign w_wr_en     = (r_state == ST_WB) && w_out_free && w_is_add && r_hit;

    vob_store #(.DEPTH(CELLS), .DW(COUNT_BITS)) u_store (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_rd_en(w_rd_en), .i_rd_addr(r_addr), .o_rd_data(w_rd_data),
        .i_wr_en(w_wr_en), .i_wr_addr(r_addr), .i_wr_data(w_inc),
        .o_busy(w_busy)
    );

    // Result word
    assign w_total_inc = (r_total == '1) ? r_total : r_total + 32'd1;

    always_comb begin
        w_result.placed      = w_is_add && r_hit;
        w_result.voxel_count = '0;
        if (r_hit) begin
            w_result.voxel_count = w_is_add ? 16'(w_inc) : 16'(w_rd_data);
        end
        w_result.points_seen = w_is_add ? w_total_inc : r_total;
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_MUL;
            ST_MUL:  n_state = ST_IDX;
            ST_IDX:  n_state = ST_ADDR;
            ST_ADDR: n_state = ST_RD;
            ST_RD:   n_state = ST_WB;
            ST_WB:   if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_WB) && w_out_free) begin
                r_out_valid <= 1'b1;
                if (w_is_add) begin
                    r_total <= w_total_inc;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_WB) && w_out_free) begin
            r_out_word <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // The datapath never runs while the clearing sweep owns the memory
    a_no_work_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !w_busy)
        else $error("datapath active during memory clear");

    // The point total never goes backwards
    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_total >= $past(r_total)))
        else $error("point total decreased");

    // A write-back never stores a wrapped counter
    a_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (w_inc != '0))
        else $error("counter wrapped to zero");

    // A result appears only out of the write-back step
    a_result_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_WB))
        else $error("result loaded outside write-back");

endmodule
